@@ design/jps_pkg.sv @@
// ----------------------------------------------------------------------------
// jps_pkg
// Shared types and codes for the Jaya population step block.
// ----------------------------------------------------------------------------
package jps_pkg;

   // request function codes
   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_ITER = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   // configuration register indexes
   localparam logic CSR_POP_SIZE  = 1'b0;
   localparam logic CSR_VAR_COUNT = 1'b1;

   // population row select
   localparam logic [1:0] ROW_CNT   = 2'd0;
   localparam logic [1:0] ROW_BEST  = 2'd1;
   localparam logic [1:0] ROW_WORST = 2'd2;
   localparam logic [1:0] ROW_REQ   = 2'd3;

   localparam logic [62:0] COST_MAX = {63{1'b1}};

   typedef struct packed {
      logic       accept;
      logic       pop_rd;
      logic       trial_rd;
      logic       pop_wr;
      logic       trial_wr;
      logic       wr_copy;
      logic [1:0] row_sel;
      logic       col_req;
      logic       rv_cap;
      logic       sq_cap;
      logic       sq_cap_t;
      logic       acc_clr;
      logic       acc_add;
      logic       cost_rd;
      logic       cost_wr;
      logic       bw_upd;
      logic       bw_first;
      logic       x_cap;
      logic       bx_cap;
      logic       wx_cap;
      logic       mul;
      logic       sum;
      logic       ce_cap;
      logic       rank_cmp;
      logic       f_lt_e;
      logic       keep_upd;
      logic       low_clr;
      logic       low_fin;
   } jps_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       oob;
      logic       kept;
   } jps_sts_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [62:0]        member_cost;
      logic [62:0]        best_cost;
      logic               status;
   } jps_res_type;

endpackage

@@ design/jaya_population_step_top.sv @@
// ----------------------------------------------------------------------------
// jaya_population_step_top
// Jaya optimizer population engine: load, read back and iterate.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_*) carries one command: load one variable,
//   run one Jaya iteration with weights r1/r2, or read one variable.
//   Every request yields exactly one response on rsp_* carrying the read
//   value, the addressed member's cost, the best cost and a status bit.
//   csr_* writes population_size (index 0) and variable_count (index 1);
//   write them only while the block is idle. Values clamp to 1..max.
// Sequencing: an iteration's survivor copy moves whole rows. The request
//   time is set by the single read port of the population and cost
//   memories: each element or cost compare uses one read. One request is
//   worked at a time; req_stall is high while busy.
// Reset: synchronous, active high. Clears control, restores sizes 8 and 2,
//   and sets the best cost to all ones. Variables are undefined until loaded.
// Stall: a finished response waits in the output register while rsp_stall
//   is high; the next request may already be accepted meanwhile, but its
//   response holds the block (req_stall high) until the register frees up.
// ----------------------------------------------------------------------------
module jaya_population_step_top
   import jps_pkg::*;
#(
   parameter int POP_MAX = 64,
   parameter int VAR_MAX = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_member,
   input  logic [4:0]         req_variable,
   input  logic signed [31:0] req_load_value,
   input  logic [15:0]        req_weight_best,
   input  logic [15:0]        req_weight_worst,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic [62:0]        rsp_member_cost,
   output logic [62:0]        rsp_best_cost,
   output logic               rsp_status,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata
);

   localparam int PW  = $clog2(POP_MAX);
   localparam int VW  = VAR_MAX > 1 ? $clog2(VAR_MAX) : 1;
   localparam int PCW = $clog2(POP_MAX + 1);
   localparam int NCW = $clog2(VAR_MAX + 1);
   localparam int PSIZE_RST = POP_MAX < 8 ? POP_MAX : 8;
   localparam int NVAR_RST  = VAR_MAX < 2 ? VAR_MAX : 2;

   // configuration, clamped on write
   logic [PCW-1:0] psize_ff, psize_in;
   logic [NCW-1:0] nvar_ff, nvar_in;
   logic [5:0]     nv_raw;

   jps_cmd_type    cmd;
   jps_sts_type    sts;
   jps_res_type    res;
   logic [PW-1:0]  cnt_row;
   logic [VW-1:0]  cnt_col;
   logic [PW:0]    cost_addr;
   logic           busy, finish, rsp_free;

   // response register
   logic           rsp_valid_ff;
   jps_res_type    rsp_ff;

   assign nv_raw = csr_wdata[5:0];

   always_comb begin
      if (csr_wdata == 7'd0) begin
         psize_in = PCW'(1);
      end else if (16'(csr_wdata) > 16'(POP_MAX)) begin
         psize_in = PCW'(POP_MAX);
      end else begin
         psize_in = PCW'(csr_wdata);
      end
      if (nv_raw == 6'd0) begin
         nvar_in = NCW'(1);
      end else if (16'(nv_raw) > 16'(VAR_MAX)) begin
         nvar_in = NCW'(VAR_MAX);
      end else begin
         nvar_in = NCW'(nv_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psize_ff <= PCW'(PSIZE_RST);
         nvar_ff  <= NCW'(NVAR_RST);
      end else if (csr_we) begin
         case (csr_index)
            CSR_POP_SIZE:  psize_ff <= psize_in;
            CSR_VAR_COUNT: nvar_ff  <= nvar_in;
            default:       psize_ff <= psize_ff;
         endcase
      end
   end

   // the output slot is free when empty or being drained this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy;

   jps_ctrl #(.POP_MAX(POP_MAX), .VAR_MAX(VAR_MAX)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_free  (rsp_free),
      .psize     (psize_ff),
      .nvar      (nvar_ff),
      .sts       (sts),
      .cmd       (cmd),
      .cnt_row   (cnt_row),
      .cnt_col   (cnt_col),
      .cost_addr (cost_addr),
      .busy      (busy),
      .finish    (finish)
   );

   jps_dpath #(.POP_MAX(POP_MAX), .VAR_MAX(VAR_MAX)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cnt_row          (cnt_row),
      .cnt_col          (cnt_col),
      .cost_addr        (cost_addr),
      .psize            (psize_ff),
      .nvar             (nvar_ff),
      .req_func         (req_func),
      .req_member       (req_member),
      .req_variable     (req_variable),
      .req_load_value   (req_load_value),
      .req_weight_best  (req_weight_best),
      .req_weight_worst (req_weight_worst),
      .sts              (sts),
      .res              (res)
   );

   // load the response on finish, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (finish) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_member_cost = rsp_ff.member_cost;
   assign rsp_best_cost   = rsp_ff.best_cost;
   assign rsp_status      = rsp_ff.status;

endmodule

@@ design/jps_ram.sv @@
// ----------------------------------------------------------------------------
// jps_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module jps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/jps_dpath.sv @@
// ----------------------------------------------------------------------------
// jps_dpath
// Datapath: population, trial and cost memories, squaring, trial update,
// best/worst tracking and rank counting.
// ----------------------------------------------------------------------------
module jps_dpath
   import jps_pkg::*;
#(
   parameter int POP_MAX = 64,
   parameter int VAR_MAX = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  jps_cmd_type                          cmd,
   input  logic [$clog2(POP_MAX)-1:0]           cnt_row,
   input  logic [(VAR_MAX > 1 ? $clog2(VAR_MAX) : 1)-1:0] cnt_col,
   input  logic [$clog2(POP_MAX):0]             cost_addr,
   input  logic [$clog2(POP_MAX+1)-1:0]         psize,
   input  logic [$clog2(VAR_MAX+1)-1:0]         nvar,
   input  logic [1:0]                           req_func,
   input  logic [5:0]                           req_member,
   input  logic [4:0]                           req_variable,
   input  logic signed [31:0]                   req_load_value,
   input  logic [15:0]                          req_weight_best,
   input  logic [15:0]                          req_weight_worst,
   output jps_sts_type                          sts,
   output jps_res_type                          res
);

   localparam int PW  = $clog2(POP_MAX);
   localparam int VW  = VAR_MAX > 1 ? $clog2(VAR_MAX) : 1;
   localparam int EW  = $clog2(2 * POP_MAX + 1);
   localparam int MD  = (2 ** PW) * (2 ** VW);
   localparam int CD  = 2 * (2 ** PW);

   // captured request
   logic [1:0]         func_ff;
   logic [5:0]         member_ff;
   logic [4:0]         variable_ff;
   logic signed [31:0] load_ff;
   logic [15:0]        r1_ff;
   logic [15:0]        r2_ff;

   logic [PW-1:0]      best_ff, worst_ff;
   logic [62:0]        bcost_ff, wcost_ff;
   logic signed [31:0] rv_ff;
   logic [62:0]        sq_ff, acc_ff, acc_in;
   logic signed [31:0] x_ff, bx_ff, wx_ff, trial_ff, trial_in;
   logic signed [50:0] p1_ff, p2_ff;
   logic [62:0]        ce_ff;
   logic [EW-1:0]      rank_ff;
   logic [62:0]        low_ff, lowest_ff;
   logic               rd_trial_ff;

   logic [PW-1:0]      req_row, row_m;
   logic [VW-1:0]      req_col, col_m;
   logic [31:0]        pop_rdata, trial_rdata, rdata;
   logic [62:0]        cost_rdata;
   logic signed [31:0] sq_src;
   logic [31:0]        sq_abs;
   logic [63:0]        sq_full, acc_sum;
   logic signed [32:0] ax;
   logic signed [33:0] db, dw;
   logic signed [16:0] r1s, r2s;
   logic signed [53:0] t_sum;
   logic signed [37:0] t_rnd;
   logic               lr_func, cf_lt;

   assign req_row = PW'(member_ff);
   assign req_col = VW'(variable_ff);

   always_comb begin
      case (cmd.row_sel)
         ROW_CNT:   row_m = cnt_row;
         ROW_BEST:  row_m = best_ff;
         ROW_WORST: row_m = worst_ff;
         ROW_REQ:   row_m = req_row;
         default:   row_m = cnt_row;
      endcase
   end
   assign col_m = cmd.col_req ? req_col : cnt_col;

   jps_ram #(.WIDTH(32), .DEPTH(MD)) u_pop (
      .clock   (clock),
      .wr_en   (cmd.pop_wr),
      .wr_addr ({row_m, col_m}),
      .wr_data (cmd.wr_copy ? rdata : load_ff),
      .rd_en   (cmd.pop_rd),
      .rd_addr ({row_m, col_m}),
      .rd_data (pop_rdata)
   );

   jps_ram #(.WIDTH(32), .DEPTH(MD)) u_trial (
      .clock   (clock),
      .wr_en   (cmd.trial_wr),
      .wr_addr ({cnt_row, cnt_col}),
      .wr_data (trial_ff),
      .rd_en   (cmd.trial_rd),
      .rd_addr ({cnt_row, cnt_col}),
      .rd_data (trial_rdata)
   );

   jps_ram #(.WIDTH(63), .DEPTH(CD)) u_cost (
      .clock   (clock),
      .wr_en   (cmd.cost_wr),
      .wr_addr (cost_addr),
      .wr_data (acc_ff),
      .rd_en   (cmd.cost_rd),
      .rd_addr (cost_addr),
      .rd_data (cost_rdata)
   );

   assign rdata = rd_trial_ff ? trial_rdata : pop_rdata;

   // square and saturating accumulate
   assign sq_src  = cmd.sq_cap_t ? trial_ff : $signed(rdata);
   assign sq_abs  = sq_src[31] ? 32'(-sq_src) : 32'(sq_src);
   assign sq_full = {32'd0, sq_abs} * {32'd0, sq_abs};
   assign acc_sum = {1'b0, acc_ff} + {1'b0, sq_ff};
   assign acc_in  = acc_sum[63] ? COST_MAX : acc_sum[62:0];

   // trial update
   assign ax  = x_ff[31] ? -{x_ff[31], x_ff} : {x_ff[31], x_ff};
   assign db  = {{2{bx_ff[31]}}, bx_ff} - {ax[32], ax};
   assign dw  = {{2{wx_ff[31]}}, wx_ff} - {ax[32], ax};
   assign r1s = {1'b0, r1_ff};
   assign r2s = {1'b0, r2_ff};
   assign t_sum = {{6{x_ff[31]}}, x_ff, 16'd0} + {{3{p1_ff[50]}}, p1_ff}
                - {{3{p2_ff[50]}}, p2_ff} + 54'sd32768;
   assign t_rnd = t_sum[53:16];
   always_comb begin
      if (t_rnd[37:31] == {7{t_rnd[31]}}) begin
         trial_in = t_rnd[31:0];
      end else if (t_rnd[37]) begin
         trial_in = 32'sh8000_0000;
      end else begin
         trial_in = 32'sh7FFF_FFFF;
      end
   end

   assign cf_lt = (cost_rdata < ce_ff) || ((cost_rdata == ce_ff) && cmd.f_lt_e);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff     <= req_func;
         member_ff   <= req_member;
         variable_ff <= req_variable;
         load_ff     <= req_load_value;
         r1_ff       <= req_weight_best;
         r2_ff       <= req_weight_worst;
      end
      if (cmd.pop_rd || cmd.trial_rd) begin
         rd_trial_ff <= cmd.trial_rd;
      end
      if (cmd.accept) begin
         rv_ff <= '0;
      end else if (cmd.rv_cap) begin
         rv_ff <= $signed(rdata);
      end
      if (cmd.sq_cap || cmd.sq_cap_t) begin
         sq_ff <= sq_full[62:0];
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_in;
      end
      if (cmd.bw_upd) begin
         if (cmd.bw_first || acc_ff < bcost_ff) begin
            best_ff  <= cnt_row;
            bcost_ff <= acc_ff;
         end
         if (cmd.bw_first || acc_ff > wcost_ff) begin
            worst_ff <= cnt_row;
            wcost_ff <= acc_ff;
         end
      end
      if (cmd.x_cap) begin
         x_ff <= $signed(rdata);
      end
      if (cmd.bx_cap) begin
         bx_ff <= $signed(rdata);
      end
      if (cmd.wx_cap) begin
         wx_ff <= $signed(rdata);
      end
      if (cmd.mul) begin
         p1_ff <= r1s * db;
         p2_ff <= r2s * dw;
      end
      if (cmd.sum) begin
         trial_ff <= trial_in;
      end
      if (cmd.ce_cap) begin
         ce_ff   <= cost_rdata;
         rank_ff <= '0;
      end else if (cmd.rank_cmp && cf_lt) begin
         rank_ff <= rank_ff + EW'(1);
      end
      if (cmd.low_clr) begin
         low_ff <= COST_MAX;
      end else if (cmd.keep_upd && ce_ff < low_ff) begin
         low_ff <= ce_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff <= COST_MAX;
      end else if (cmd.low_fin) begin
         lowest_ff <= low_ff;
      end
   end

   assign lr_func  = (func_ff == FUNC_LOAD) || (func_ff == FUNC_READ);
   assign sts.func = func_ff;
   assign sts.oob  = (16'(member_ff) >= 16'(psize)) || (16'(variable_ff) >= 16'(nvar));
   assign sts.kept = 16'(rank_ff) < 16'(psize);

   assign res.read_value  = rv_ff;
   assign res.member_cost = (lr_func && !sts.oob) ? acc_ff : 63'd0;
   assign res.best_cost   = lowest_ff;
   assign res.status      = lr_func && sts.oob;

endmodule

@@ design/jps_ctrl.sv @@
// ----------------------------------------------------------------------------
// jps_ctrl
// Sequencer: walks rows and columns for scoring, trial update, ranking and
// row copy, and drives the datapath commands.
// ----------------------------------------------------------------------------
module jps_ctrl
   import jps_pkg::*;
#(
   parameter int POP_MAX = 64,
   parameter int VAR_MAX = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 rsp_free,
   input  logic [$clog2(POP_MAX+1)-1:0]         psize,
   input  logic [$clog2(VAR_MAX+1)-1:0]         nvar,
   input  jps_sts_type                          sts,
   output jps_cmd_type                          cmd,
   output logic [$clog2(POP_MAX)-1:0]           cnt_row,
   output logic [(VAR_MAX > 1 ? $clog2(VAR_MAX) : 1)-1:0] cnt_col,
   output logic [$clog2(POP_MAX):0]             cost_addr,
   output logic                                 busy,
   output logic                                 finish
);

   localparam int PW  = $clog2(POP_MAX);
   localparam int VW  = VAR_MAX > 1 ? $clog2(VAR_MAX) : 1;
   localparam int PCW = $clog2(POP_MAX + 1);
   localparam int NCW = $clog2(VAR_MAX + 1);
   localparam int EW  = $clog2(2 * POP_MAX + 1);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DISP   = 5'd1;
   localparam logic [4:0] S_LR_RD  = 5'd2;
   localparam logic [4:0] S_SC_RD  = 5'd3;
   localparam logic [4:0] S_SC_SQ  = 5'd4;
   localparam logic [4:0] S_SC_ACC = 5'd5;
   localparam logic [4:0] S_SC_END = 5'd6;
   localparam logic [4:0] S_TR_X   = 5'd7;
   localparam logic [4:0] S_TR_B   = 5'd8;
   localparam logic [4:0] S_TR_W   = 5'd9;
   localparam logic [4:0] S_TR_M   = 5'd10;
   localparam logic [4:0] S_TR_MUL = 5'd11;
   localparam logic [4:0] S_TR_SUM = 5'd12;
   localparam logic [4:0] S_TR_WR  = 5'd13;
   localparam logic [4:0] S_TR_ACC = 5'd14;
   localparam logic [4:0] S_TR_END = 5'd15;
   localparam logic [4:0] S_RK_E   = 5'd16;
   localparam logic [4:0] S_RK_CE  = 5'd17;
   localparam logic [4:0] S_RK_F   = 5'd18;
   localparam logic [4:0] S_RK_CMP = 5'd19;
   localparam logic [4:0] S_RK_DEC = 5'd20;
   localparam logic [4:0] S_CP_RD  = 5'd21;
   localparam logic [4:0] S_CP_WR  = 5'd22;
   localparam logic [4:0] S_FIN    = 5'd23;
   localparam logic [4:0] S_DONE   = 5'd24;

   logic [4:0]     state_ff, state_in;
   logic [PCW-1:0] i_ff, i_in, k_ff, k_in;
   logic [NCW-1:0] j_ff, j_in;
   logic [EW-1:0]  e_ff, e_in, f_ff, f_in;
   logic           lr_ff, lr_in;

   logic           j_last, v_last, i_last, e_last, f_last, e_old, f_old;
   logic [15:0]    two_p;
   logic [EW-1:0]  e_sub, f_sub;
   logic [PW-1:0]  e_row;
   logic [PW:0]    e_addr, f_addr;

   assign two_p  = 16'(psize) + 16'(psize);
   assign j_last = (16'(j_ff) + 16'd1) == 16'(nvar);
   assign v_last = (16'(j_ff) + 16'd1) == 16'(VAR_MAX);
   assign i_last = (16'(i_ff) + 16'd1) == 16'(psize);
   assign e_last = (16'(e_ff) + 16'd1) == two_p;
   assign f_last = (16'(f_ff) + 16'd1) == two_p;
   assign e_old  = 16'(e_ff) < 16'(psize);
   assign f_old  = 16'(f_ff) < 16'(psize);
   assign e_sub  = e_ff - EW'(psize);
   assign f_sub  = f_ff - EW'(psize);
   assign e_row  = e_old ? e_ff[PW-1:0] : e_sub[PW-1:0];
   assign e_addr = e_old ? {1'b0, e_ff[PW-1:0]} : {1'b1, e_sub[PW-1:0]};
   assign f_addr = f_old ? {1'b0, f_ff[PW-1:0]} : {1'b1, f_sub[PW-1:0]};

   assign cnt_col = j_ff[VW-1:0];
   assign busy    = state_ff != S_IDLE;
   assign finish  = (state_ff == S_DONE) && rsp_free;

   always_comb begin
      case (state_ff)
         S_CP_RD: cnt_row = e_row;
         S_CP_WR: cnt_row = k_ff[PW-1:0];
         default: cnt_row = i_ff[PW-1:0];
      endcase
   end

   always_comb begin
      case (state_ff)
         S_SC_END: cost_addr = {1'b0, i_ff[PW-1:0]};
         S_TR_END: cost_addr = {1'b1, i_ff[PW-1:0]};
         S_RK_F:   cost_addr = f_addr;
         default:  cost_addr = e_addr;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      e_in     = e_ff;
      f_in     = f_ff;
      k_in     = k_ff;
      lr_in    = lr_ff;
      cmd      = '0;
      cmd.f_lt_e = f_ff < e_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               j_in       = '0;
               state_in   = S_DISP;
            end
         end
         S_DISP: begin
            cmd.acc_clr = 1'b1;
            j_in        = '0;
            i_in        = '0;
            case (sts.func)
               FUNC_LOAD: begin
                  lr_in = 1'b1;
                  if (sts.oob) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.pop_wr  = 1'b1;
                     cmd.row_sel = ROW_REQ;
                     cmd.col_req = 1'b1;
                     state_in    = S_SC_RD;
                  end
               end
               FUNC_READ: begin
                  lr_in = 1'b1;
                  if (sts.oob) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.pop_rd  = 1'b1;
                     cmd.row_sel = ROW_REQ;
                     cmd.col_req = 1'b1;
                     state_in    = S_LR_RD;
                  end
               end
               FUNC_ITER: begin
                  lr_in       = 1'b0;
                  cmd.low_clr = 1'b1;
                  state_in    = S_SC_RD;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_LR_RD: begin
            cmd.rv_cap = 1'b1;
            state_in   = S_SC_RD;
         end
         S_SC_RD: begin
            cmd.pop_rd  = 1'b1;
            cmd.row_sel = lr_ff ? ROW_REQ : ROW_CNT;
            state_in    = S_SC_SQ;
         end
         S_SC_SQ: begin
            cmd.sq_cap = 1'b1;
            state_in   = S_SC_ACC;
         end
         S_SC_ACC: begin
            cmd.acc_add = 1'b1;
            if (j_last) begin
               state_in = S_SC_END;
            end else begin
               j_in     = j_ff + NCW'(1);
               state_in = S_SC_RD;
            end
         end
         S_SC_END: begin
            if (lr_ff) begin
               state_in = S_DONE;
            end else begin
               cmd.cost_wr  = 1'b1;
               cmd.bw_upd   = 1'b1;
               cmd.bw_first = i_ff == '0;
               cmd.acc_clr  = 1'b1;
               j_in         = '0;
               if (i_last) begin
                  i_in     = '0;
                  state_in = S_TR_X;
               end else begin
                  i_in     = i_ff + PCW'(1);
                  state_in = S_SC_RD;
               end
            end
         end
         S_TR_X: begin
            cmd.pop_rd = 1'b1;
            state_in   = S_TR_B;
         end
         S_TR_B: begin
            cmd.x_cap   = 1'b1;
            cmd.pop_rd  = 1'b1;
            cmd.row_sel = ROW_BEST;
            state_in    = S_TR_W;
         end
         S_TR_W: begin
            cmd.bx_cap  = 1'b1;
            cmd.pop_rd  = 1'b1;
            cmd.row_sel = ROW_WORST;
            state_in    = S_TR_M;
         end
         S_TR_M: begin
            cmd.wx_cap = 1'b1;
            state_in   = S_TR_MUL;
         end
         S_TR_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_TR_SUM;
         end
         S_TR_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_TR_WR;
         end
         S_TR_WR: begin
            cmd.trial_wr = 1'b1;
            cmd.sq_cap_t = 1'b1;
            state_in     = S_TR_ACC;
         end
         S_TR_ACC: begin
            cmd.acc_add = 1'b1;
            if (j_last) begin
               state_in = S_TR_END;
            end else begin
               j_in     = j_ff + NCW'(1);
               state_in = S_TR_X;
            end
         end
         S_TR_END: begin
            cmd.cost_wr = 1'b1;
            cmd.acc_clr = 1'b1;
            j_in        = '0;
            if (i_last) begin
               i_in     = '0;
               e_in     = '0;
               k_in     = '0;
               state_in = S_RK_E;
            end else begin
               i_in     = i_ff + PCW'(1);
               state_in = S_TR_X;
            end
         end
         S_RK_E: begin
            cmd.cost_rd = 1'b1;
            state_in    = S_RK_CE;
         end
         S_RK_CE: begin
            cmd.ce_cap = 1'b1;
            f_in       = '0;
            state_in   = S_RK_F;
         end
         S_RK_F: begin
            cmd.cost_rd = 1'b1;
            state_in    = S_RK_CMP;
         end
         S_RK_CMP: begin
            cmd.rank_cmp = 1'b1;
            if (f_last) begin
               state_in = S_RK_DEC;
            end else begin
               f_in     = f_ff + EW'(1);
               state_in = S_RK_F;
            end
         end
         S_RK_DEC: begin
            if (sts.kept) begin
               cmd.keep_upd = 1'b1;
               j_in         = '0;
               state_in     = S_CP_RD;
            end else if (e_last) begin
               state_in = S_FIN;
            end else begin
               e_in     = e_ff + EW'(1);
               state_in = S_RK_E;
            end
         end
         // move the whole row, all VAR_MAX columns
         S_CP_RD: begin
            cmd.pop_rd   = e_old;
            cmd.trial_rd = !e_old;
            state_in     = S_CP_WR;
         end
         S_CP_WR: begin
            cmd.pop_wr  = 1'b1;
            cmd.wr_copy = 1'b1;
            if (!v_last) begin
               j_in     = j_ff + NCW'(1);
               state_in = S_CP_RD;
            end else begin
               k_in = k_ff + PCW'(1);
               if (e_last) begin
                  state_in = S_FIN;
               end else begin
                  e_in     = e_ff + EW'(1);
                  state_in = S_RK_E;
               end
            end
         end
         S_FIN: begin
            cmd.low_fin = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff  <= i_in;
      j_ff  <= j_in;
      e_ff  <= e_in;
      f_ff  <= f_in;
      k_ff  <= k_in;
      lr_ff <= lr_in;
   end

`ifndef SYNTH
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SC_RD || state_ff == S_TR_X) |-> 16'(j_ff) < 16'(nvar))
      else $error("column counter beyond variable count");

   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RK_F || state_ff == S_RK_CMP) |-> 16'(f_ff) < two_p)
      else $error("rank scan beyond combined population");

   a_keep_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CP_RD |-> 16'(k_ff) < 16'(psize))
      else $error("more rows kept than population size");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_DISP)
      else $error("accepted request not dispatched");
`endif

endmodule

@@ verif/jaya_population_step_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaya_population_step_top_tb
// Self-checking bench for the Jaya population engine. Rows 0 to 7 are filled
// over four variables, one variable width at a time, and a first iteration at
// that size writes every trial entry later runs can pick up. All further
// traffic stays within eight members and four variables, so no cost, read or
// iteration ever touches a variable that was never loaded. Directed requests
// cover the size clamps, out-of-range addresses, the unused code and the
// value extremes; random phases follow. A built-in population predictor works
// out each response, and the monitor compares every response field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module jaya_population_step_top_tb;
   import jps_pkg::*;

   localparam int POP_LIMIT = 64;
   localparam int VAR_LIMIT = 32;
   localparam int POP_TEST  = 8;
   localparam int VAR_TEST  = 4;

   typedef struct {
      logic [1:0]         func;
      logic [5:0]         member;
      logic [4:0]         variable;
      logic signed [31:0] load_value;
      logic [15:0]        weight_best;
      logic [15:0]        weight_worst;
   } jaya_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = FUNC_LOAD;
   logic [5:0]         req_member = '0;
   logic [4:0]         req_variable = '0;
   logic signed [31:0] req_load_value = '0;
   logic [15:0]        req_weight_best = '0;
   logic [15:0]        req_weight_worst = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic [62:0]        rsp_member_cost;
   logic [62:0]        rsp_best_cost;
   logic               rsp_status;
   logic               csr_we = 1'b0;
   logic               csr_index = CSR_POP_SIZE;
   logic [6:0]         csr_wdata = '0;

   jaya_population_step_top uut (.*);

   always #5 clock = ~clock;

   // Predictor state: the population as the block should hold it.
   int          pop_rows   [POP_LIMIT][VAR_LIMIT];
   int          trial_rows [POP_LIMIT][VAR_LIMIT];
   int          next_rows  [POP_LIMIT][VAR_LIMIT];
   logic [62:0] old_cost   [POP_LIMIT];
   logic [62:0] trial_cost [POP_LIMIT];
   logic [62:0] lowest_cost = COST_MAX;
   int          pop_eff = 8;
   int          var_eff = 2;

   jaya_req_type pending_q[$];
   jps_res_type  response_q[$];
   int           mismatch_count = 0;
   bit           quiet = 1'b0;     // no idling on either side
   bit           req_taken = 1'b0;
   int           req_gap = 0;
   int           rsp_gap = 0;

   function automatic logic [62:0] sum_of_squares(input int row[VAR_LIMIT], input int n);
      logic [63:0] acc;
      logic [63:0] mag;
      logic [63:0] sq;
      acc = 0;
      for (int j = 0; j < n; j++) begin
         mag = row[j] < 0 ? -longint'(row[j]) : longint'(row[j]);
         sq = mag * mag;
         if (acc > {1'b0, COST_MAX} - sq) acc = {1'b0, COST_MAX};
         else acc = acc + sq;
      end
      return acc[62:0];
   endfunction

   function automatic int jaya_move(input int x, input int bx, input int wx,
                                    input int r1, input int r2);
      longint ax;
      longint t;
      longint r;
      ax = x < 0 ? -longint'(x) : longint'(x);
      t = longint'(x) * 65536 + longint'(r1) * (longint'(bx) - ax)
          - longint'(r2) * (longint'(wx) - ax);
      r = (t + 32768) >>> 16;   // round to nearest, ties up
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return int'(r);
   endfunction

   task automatic jaya_iterate(input int r1, input int r2);
      int best;
      int worst;
      int rank;
      int kept;
      logic [62:0] ce;
      logic [62:0] cf;
      logic [62:0] low;
      best = 0; worst = 0; kept = 0; low = COST_MAX;
      for (int i = 0; i < pop_eff; i++) old_cost[i] = sum_of_squares(pop_rows[i], var_eff);
      for (int i = 1; i < pop_eff; i++) begin
         if (old_cost[i] < old_cost[best]) best = i;
         if (old_cost[i] > old_cost[worst]) worst = i;
      end
      for (int i = 0; i < pop_eff; i++) begin
         for (int j = 0; j < var_eff; j++)
            trial_rows[i][j] = jaya_move(pop_rows[i][j], pop_rows[best][j],
                                         pop_rows[worst][j], r1, r2);
         trial_cost[i] = sum_of_squares(trial_rows[i], var_eff);
      end
      // rank old plus trial; equal costs favor old, then lower index
      for (int e = 0; e < 2 * pop_eff; e++) begin
         ce = e < pop_eff ? old_cost[e] : trial_cost[e - pop_eff];
         rank = 0;
         for (int f = 0; f < 2 * pop_eff; f++) begin
            cf = f < pop_eff ? old_cost[f] : trial_cost[f - pop_eff];
            if (cf < ce || (cf == ce && f < e)) rank++;
         end
         if (rank < pop_eff && kept < pop_eff) begin
            if (e < pop_eff) next_rows[kept] = pop_rows[e];
            else next_rows[kept] = trial_rows[e - pop_eff];
            if (ce < low) low = ce;
            kept++;
         end
      end
      for (int i = 0; i < kept; i++) pop_rows[i] = next_rows[i];
      lowest_cost = low;
   endtask

   task automatic predict_response(input jaya_req_type rq);
      jps_res_type res;
      res = '{read_value: '0, member_cost: '0, best_cost: '0, status: 1'b0};
      if (rq.func == FUNC_LOAD || rq.func == FUNC_READ) begin
         if (rq.member >= pop_eff || rq.variable >= var_eff) begin
            res.status = 1'b1;
         end else begin
            if (rq.func == FUNC_LOAD) pop_rows[rq.member][rq.variable] = rq.load_value;
            else res.read_value = pop_rows[rq.member][rq.variable];
            res.member_cost = sum_of_squares(pop_rows[rq.member], var_eff);
         end
      end else if (rq.func == FUNC_ITER) begin
         jaya_iterate(rq.weight_best, rq.weight_worst);
      end
      res.best_cost = lowest_cost;
      response_q.insert(response_q.size(), res);
   endtask

   // Sample the request channel and predict on every accepted request.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_response('{req_func, req_member, req_variable, req_load_value,
                            req_weight_best, req_weight_worst});
         req_taken = 1'b1;
      end
   end

   // Driver: hold a stalled request, advance after acceptance, idle in bursts.
   always @(negedge clock) begin
      jaya_req_type rq;
      logic next_valid;
      next_valid = req_valid;
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(1, 17) - 1;
         end else if (pending_q.size() > 0) begin
            rq = pending_q.pop_front();
            req_func <= rq.func;
            req_member <= rq.member;
            req_variable <= rq.variable;
            req_load_value <= rq.load_value;
            req_weight_best <= rq.weight_best;
            req_weight_worst <= rq.weight_worst;
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
   end

   // Response stall in random bursts.
   always @(negedge clock) begin
      logic next_stall;
      next_stall = 1'b0;
      if (rsp_gap > 0) begin
         rsp_gap--;
         next_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(1, 17) - 1;
         next_stall = 1'b1;
      end
      rsp_stall <= next_stall;
   end

   // Monitor: compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      jps_res_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (response_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response at %0t", $time);
         end else begin
            exp_res = response_q.pop_front();
            if (rsp_read_value !== exp_res.read_value || rsp_member_cost !== exp_res.member_cost
                || rsp_best_cost !== exp_res.best_cost || rsp_status !== exp_res.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: exp val %h cost %h best %h st %b, got %h %h %h %b",
                           $time, exp_res.read_value, exp_res.member_cost, exp_res.best_cost,
                           exp_res.status, rsp_read_value, rsp_member_cost, rsp_best_cost,
                           rsp_status);
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_q.size() != 0 || response_q.size() != 0 || req_valid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write one register once the block has drained, and track it.
   task automatic write_csr(input logic idx, input logic [6:0] value);
      int v;
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_POP_SIZE) begin
         v = value;
         pop_eff = v < 1 ? 1 : (v > POP_LIMIT ? POP_LIMIT : v);
      end else begin
         v = value[5:0];
         var_eff = v < 1 ? 1 : (v > VAR_LIMIT ? VAR_LIMIT : v);
      end
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 16'hffff)) - 32768);
         default: return 32'($signed($urandom_range(0, 24'hffffff)) - 24'h800000);
      endcase
   endfunction

   task automatic push_req(input logic [1:0] func, input int m, input int v,
                           input logic [31:0] lv, input int r1, input int r2);
      jaya_req_type rq;
      rq.func = func;
      rq.member = 6'(m);
      rq.variable = 5'(v);
      rq.load_value = lv;
      rq.weight_best = 16'(r1);
      rq.weight_worst = 16'(r2);
      pending_q.insert(pending_q.size(), rq);
   endtask

   // Random phase: mostly loads and reads, mostly in range, with iterations and the unused code.
   task automatic random_phase(input int count);
      int m;
      int v;
      int pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 19);
         m = $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(0, pop_eff - 1);
         v = $urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(0, var_eff - 1);
         if (pick < 7)
            push_req(FUNC_LOAD, m, v, pick_value(), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
         else if (pick < 13)
            push_req(FUNC_READ, m, v, $urandom(), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
         else if (pick < 19)
            push_req(FUNC_ITER, m, v, $urandom(), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
         else
            push_req(2'd3, m, v, $urandom(), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Out-of-range addresses and the unused code touch no stored variable.
      push_req(FUNC_LOAD, 8, 0, 32'h1234_5678, 0, 0);
      push_req(FUNC_READ, 0, 2, 0, 0, 0);
      push_req(FUNC_READ, 63, 31, 0, 65535, 65535);
      push_req(FUNC_LOAD, 63, 31, 32'hffff_ffff, 0, 0);
      push_req(2'd3, 0, 0, 32'hdead_beef, 65535, 65535);

      // Fill the test rows one variable at a time: each row cost then only
      // covers variables already loaded.
      write_csr(CSR_POP_SIZE, 7'(POP_TEST));
      for (int n = 1; n <= VAR_TEST; n++) begin
         write_csr(CSR_VAR_COUNT, 7'(n));
         for (int m = 0; m < POP_TEST; m++)
            push_req(FUNC_LOAD, m, n - 1, pick_value(), 0, 0);
      end
      // First iteration at the full test size writes every trial entry.
      push_req(FUNC_ITER, 0, 0, 0, $urandom_range(0, 65535), $urandom_range(0, 65535));

      // Size clamps at the low end; weights at both extremes.
      write_csr(CSR_POP_SIZE, 7'd0);
      write_csr(CSR_VAR_COUNT, 7'd0);
      push_req(FUNC_ITER, 0, 0, 0, 0, 0);
      push_req(FUNC_READ, 0, 0, 0, 0, 0);
      push_req(FUNC_READ, 1, 0, 0, 0, 0);
      write_csr(CSR_POP_SIZE, 7'd2);
      write_csr(CSR_VAR_COUNT, 7'd2);
      push_req(FUNC_LOAD, 0, 0, 32'h7fff_ffff, 0, 0);
      push_req(FUNC_LOAD, 1, 1, 32'h8000_0000, 0, 0);
      push_req(FUNC_ITER, 0, 0, 0, 65535, 65535);
      push_req(FUNC_READ, 0, 1, 0, 0, 0);
      push_req(FUNC_ITER, 0, 0, 0, 65535, 0);

      // Clamp writes at the high end.
      write_csr(CSR_POP_SIZE, 7'd127);
      write_csr(CSR_VAR_COUNT, 7'd63);
      push_req(2'd3, 0, 0, 0, 0, 0);

      // Random phases within the test size; pauses for the drain at each write.
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_POP_SIZE, 7'($urandom_range(1, POP_TEST)));
         write_csr(CSR_VAR_COUNT, 7'($urandom_range(1, VAR_TEST)));
         random_phase(8);
      end

      // Closing phase with no idling on either side.
      write_csr(CSR_POP_SIZE, 7'($urandom_range(2, POP_TEST)));
      write_csr(CSR_VAR_COUNT, 7'($urandom_range(1, VAR_TEST)));
      quiet = 1'b1;
      random_phase(10);

      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && response_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ jaya_population_step_top.f @@
design/jps_pkg.sv
design/jps_ram.sv
design/jps_dpath.sv
design/jps_ctrl.sv
design/jaya_population_step_top.sv
verif/jaya_population_step_top_tb.sv
